[src/eis_pkg.sv]
package eis_pkg;

   // signed width of best - mean + margin + penalty
   localparam int DIFF_W = 35;
   // magnitude of that difference
   localparam int MAG_W = 34;
   // phi and Phi table words, Q30 up to 1.0
   localparam int TAB_W = 31;
   // wide signed products ahead of saturation
   localparam int WIDE_W = 66;

   // register indexes of the configuration port
   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_BEST    = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_MARGIN  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_PENALTY = 2'd2;

   // table generation constants
   localparam longint ONE_Q30 = longint'(1) << 30;
   localparam longint LN2_Q30 = 744261118;
   localparam longint INV_SQRT_2PI_Q30 = 428361012;

   localparam logic signed [WIDE_W-1:0] S32_MAX = {{(WIDE_W-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [WIDE_W-1:0] S32_MIN = {{(WIDE_W-31){1'b1}}, {31{1'b0}}};

   // per-item sideband carried down the pipeline
   typedef struct packed {
      logic [30:0]               sd;
      logic signed [31:0]        ms;
      logic signed [31:0]        ss;
      logic signed [DIFF_W-1:0]  diff;
      logic                      neg;
      logic                      ovf;
      logic                      zero;
   } eis_side_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
      if (v > S32_MAX) begin
         return 32'sh7FFFFFFF;
      end else if (v < S32_MIN) begin
         return 32'sh80000000;
      end
      return $signed(v[31:0]);
   endfunction

endpackage

[src/expected_improvement_score_top.sv]
// expected improvement score, one item per clock cycle, fully pipelined
// path: difference, magnitude, divider, offset, index, table read, score stages
// depth set by the divider, one quotient bit per stage, FRACTION_BITS + 4 stages
// busy is never raised and the receiver cannot stall; csr writes complete at once
// synchronous active-high reset clears the configuration registers to zero and all valid bits
module expected_improvement_score_top #(
   parameter int TABLE_ENTRIES = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [31:0]            req_pred_mean,
   input  logic [30:0]                   req_pred_sd,
   input  logic signed [31:0]            req_mean_slope,
   input  logic signed [31:0]            req_sd_slope,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [eis_pkg::CSR_IW-1:0]    csr_index,
   input  logic [31:0]                   csr_data,
   output logic                          rsp_strobe,
   output logic signed [31:0]            rsp_criterion,
   output logic signed [31:0]            rsp_partial_slope,
   output logic                          rsp_sd_zero
);
   import eis_pkg::*;

   localparam int QB  = FRACTION_BITS + 4;
   localparam int UW  = FRACTION_BITS + 5;
   localparam int OW  = FRACTION_BITS + 4;
   localparam int IW  = $clog2(TABLE_ENTRIES);
   localparam int TEW = IW + 1;
   localparam int LAT = QB + 9;
   localparam logic [QB-1:0] LIM_Q = QB'(longint'(1) << (FRACTION_BITS + 3));

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers
   logic signed [31:0] best_ff;
   logic [30:0]        margin_ff, penalty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff    <= '0;
         margin_ff  <= '0;
         penalty_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BEST:    best_ff    <= csr_data;
            CSR_MARGIN:  margin_ff  <= csr_data[30:0];
            CSR_PENALTY: penalty_ff <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // improvement difference
   logic signed [DIFF_W-1:0] a_diff_in, a_diff_ff;
   logic [30:0]              a_sd_ff;
   logic signed [31:0]       a_ms_ff, a_ss_ff;
   logic                     a_vld_ff;

   assign a_diff_in = DIFF_W'(best_ff) - DIFF_W'(req_pred_mean)
                    + DIFF_W'(margin_ff) + DIFF_W'(penalty_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
      end
      a_diff_ff <= a_diff_in;
      a_sd_ff   <= req_pred_sd;
      a_ms_ff   <= req_mean_slope;
      a_ss_ff   <= req_sd_slope;
   end

   // magnitude and quotient overflow check
   logic [MAG_W-1:0] b_mag_in, b_mag_ff;
   eis_side_type     b_side_in, b_side_ff;
   logic             b_vld_ff;

   assign b_mag_in = a_diff_ff[DIFF_W-1] ? MAG_W'(-a_diff_ff) : MAG_W'(a_diff_ff);

   always_comb begin
      b_side_in.sd   = a_sd_ff;
      b_side_in.ms   = a_ms_ff;
      b_side_in.ss   = a_ss_ff;
      b_side_in.diff = a_diff_ff;
      b_side_in.neg  = a_diff_ff[DIFF_W-1];
      b_side_in.ovf  = {1'b0, b_mag_in} >= {a_sd_ff, 4'b0000};
      b_side_in.zero = a_sd_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_mag_ff  <= b_mag_in;
      b_side_ff <= b_side_in;
   end

   // u = diff / sd in fixed point
   logic          d_vld;
   logic [QB-1:0] d_quo;
   eis_side_type  d_side;

   eis_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (b_vld_ff),
      .mag      (b_mag_ff),
      .in_side  (b_side_ff),
      .out_vld  (d_vld),
      .quo      (d_quo),
      .out_side (d_side)
   );

   // sign, range ends and table offset
   logic signed [UW-1:0] u_u_in, u_u_ff;
   logic [OW-1:0]        u_off_in, u_off_ff;
   logic                 u_hi_in, u_lo_in, u_hi_ff, u_lo_ff, u_vld_ff;
   eis_side_type         u_side_ff;

   assign u_u_in   = d_side.neg ? -UW'(d_quo) : UW'(d_quo);
   assign u_off_in = d_side.neg ? OW'(LIM_Q - d_quo) : OW'(LIM_Q + d_quo);
   assign u_hi_in  = !d_side.neg && (d_side.ovf || d_quo >= LIM_Q);
   assign u_lo_in  = d_side.neg && (d_side.ovf || d_quo > LIM_Q);

   always_ff @(posedge clock) begin
      if (reset) begin
         u_vld_ff <= 1'b0;
      end else begin
         u_vld_ff <= d_vld;
      end
      u_u_ff    <= u_u_in;
      u_off_ff  <= u_off_in;
      u_hi_ff   <= u_hi_in;
      u_lo_ff   <= u_lo_in;
      u_side_ff <= d_side;
   end

   // table index
   logic [OW+TEW-1:0]    i_prod;
   logic [IW-1:0]        i_idx_ff;
   logic signed [UW-1:0] i_u_ff;
   logic                 i_hi_ff, i_lo_ff, i_vld_ff;
   eis_side_type         i_side_ff;

   assign i_prod = (OW+TEW)'(u_off_ff) * (OW+TEW)'(TABLE_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
      end else begin
         i_vld_ff <= u_vld_ff;
      end
      i_idx_ff  <= i_prod[OW +: IW];
      i_u_ff    <= u_u_ff;
      i_hi_ff   <= u_hi_ff;
      i_lo_ff   <= u_lo_ff;
      i_side_ff <= u_side_ff;
   end

   // phi and Phi lookup, alongside the sideband
   logic [TAB_W-1:0]     r_pdf, r_cdf;
   logic signed [UW-1:0] r_u_ff;
   logic                 r_hi_ff, r_lo_ff, r_vld_ff;
   eis_side_type         r_side_ff;

   eis_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
      .clock (clock),
      .addr  (i_idx_ff),
      .pdf   (r_pdf),
      .cdf   (r_cdf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else begin
         r_vld_ff <= i_vld_ff;
      end
      r_u_ff    <= i_u_ff;
      r_hi_ff   <= i_hi_ff;
      r_lo_ff   <= i_lo_ff;
      r_side_ff <= i_side_ff;
   end

   // products, scaling and result register
   eis_score #(.FRACTION_BITS(FRACTION_BITS)) u_score (
      .clock             (clock),
      .reset             (reset),
      .in_vld            (r_vld_ff),
      .u                 (r_u_ff),
      .cdf               (r_cdf),
      .pdf               (r_pdf),
      .side              (r_side_ff),
      .hi                (r_hi_ff),
      .lo                (r_lo_ff),
      .rsp_strobe        (rsp_strobe),
      .rsp_criterion     (rsp_criterion),
      .rsp_partial_slope (rsp_partial_slope),
      .rsp_sd_zero       (rsp_sd_zero)
   );

`ifndef SYNTHESIS
   // each accepted item gives exactly one result beat after the fixed latency
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_strobe)
      else $error("accepted item produced no result beat");
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LAT))
      else $error("result beat without an accepted item");
`endif

endmodule

[src/eis_div.sv]
module eis_div #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_vld,
   input  logic [eis_pkg::MAG_W-1:0]    mag,
   input  eis_pkg::eis_side_type        in_side,
   output logic                         out_vld,
   output logic [FRACTION_BITS+3:0]     quo,
   output eis_pkg::eis_side_type        out_side
);
   import eis_pkg::*;

   localparam int QB = FRACTION_BITS + 4;
   localparam int RW = 31;

   logic [RW-1:0]  rem_ff  [QB];
   logic [QB-1:0]  quo_ff  [QB];
   logic [3:0]     low_ff  [QB];
   eis_side_type   side_ff [QB];
   logic [QB-1:0]  vld_ff;

   // restoring division, one quotient bit per stage
   for (genvar g = 0; g < QB; g++) begin : g_step
      logic [RW-1:0] rem_src;
      logic [QB-1:0] quo_src;
      logic [3:0]    low_src;
      eis_side_type  side_src;
      logic          vld_src;
      logic          bit_src;
      logic [RW:0]   trial;
      logic          take;
      logic [RW-1:0] rem_in;
      logic [QB-1:0] quo_in;

      if (g == 0) begin : g_first
         assign rem_src  = {1'b0, mag[MAG_W-1:4]};
         assign quo_src  = '0;
         assign low_src  = mag[3:0];
         assign side_src = in_side;
         assign vld_src  = in_vld;
      end else begin : g_next
         assign rem_src  = rem_ff[g-1];
         assign quo_src  = quo_ff[g-1];
         assign low_src  = low_ff[g-1];
         assign side_src = side_ff[g-1];
         assign vld_src  = vld_ff[g-1];
      end

      // low magnitude bits first, then the fraction zeros
      if (g < 4) begin : g_low
         assign bit_src = low_src[3-g];
      end else begin : g_zero
         assign bit_src = 1'b0;
      end

      assign trial  = {rem_src, bit_src};
      assign take   = trial >= {1'b0, side_src.sd};
      assign rem_in = take ? RW'(trial - {1'b0, side_src.sd}) : trial[RW-1:0];
      assign quo_in = {quo_src[QB-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_src;
         end
         rem_ff[g]  <= rem_in;
         quo_ff[g]  <= quo_in;
         low_ff[g]  <= low_src;
         side_ff[g] <= side_src;
      end
   end

   assign out_vld  = vld_ff[QB-1];
   assign quo      = quo_ff[QB-1];
   assign out_side = side_ff[QB-1];

`ifndef SYNTHESIS
   // a quotient in range leaves a remainder below the divisor
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[QB-1] && !side_ff[QB-1].ovf && !side_ff[QB-1].zero
      |-> rem_ff[QB-1] < side_ff[QB-1].sd)
      else $error("divider remainder not below divisor");
`endif

endmodule

[src/eis_table.sv]
module eis_table #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic                              clock,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]  addr,
   output logic [eis_pkg::TAB_W-1:0]         pdf,
   output logic [eis_pkg::TAB_W-1:0]         cdf
);
   import eis_pkg::*;

   typedef logic [2*TAB_W-1:0] rom_type [TABLE_ENTRIES];

   // unsigned long division, only evaluated while the constant table is built
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int bi = 63; bi >= 0; bi--) begin
         r = {r[62:0], num[bi]};
         if (r >= den) begin
            r = r - den;
            q[bi] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-x) in Q30, range reduced by ln2 then a Taylor series
   function automatic longint exp_neg(input longint unsigned x);
      longint unsigned k;
      longint unsigned rem;
      longint r;
      longint term;
      longint sum;
      rem = x;
      k = 0;
      while (rem >= LN2_Q30 && k < 62) begin
         rem = rem - LN2_Q30;
         k = k + 1;
      end
      if (k >= 62) begin
         return 0;
      end
      r = longint'(rem);
      term = ONE_Q30;
      sum = ONE_Q30;
      for (int n = 1; n <= 13; n++) begin
         term = longint'(udiv((term * r) >>> 30, longint'(n)));
         if (n[0]) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return sum >>> k;
   endfunction

   // phi on the half grid, Q30
   function automatic longint pdf_half(input longint j);
      longint d;
      longint unsigned sq;
      longint unsigned x;
      d = j - TABLE_ENTRIES;
      sq = longint'(d * d);
      x = udiv(sq << 35, longint'(TABLE_ENTRIES) * longint'(TABLE_ENTRIES));
      return (exp_neg(x) * INV_SQRT_2PI_Q30) >>> 30;
   endfunction

   // phi at each left bin edge, Phi by Simpson accumulation
   function automatic rom_type build_rom();
      rom_type t;
      longint acc;
      longint a;
      longint m;
      longint b;
      acc = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         a = pdf_half(2 * i);
         m = pdf_half(2 * i + 1);
         b = pdf_half(2 * i + 2);
         t[i] = {TAB_W'(a), TAB_W'(acc)};
         acc = acc + longint'(udiv(longint'(8 * (a + 4 * m + b)),
                                   3 * longint'(TABLE_ENTRIES)));
         if (acc > ONE_Q30) begin
            acc = ONE_Q30;
         end
      end
      return t;
   endfunction

   localparam rom_type ROM = build_rom();

   logic [2*TAB_W-1:0] rd_in;
   logic [2*TAB_W-1:0] rd_ff;

   // registered rom read
   assign rd_in = ROM[addr];

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
   end

   assign pdf = rd_ff[2*TAB_W-1:TAB_W];
   assign cdf = rd_ff[TAB_W-1:0];

endmodule

[src/eis_score.sv]
module eis_score #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_vld,
   input  logic signed [FRACTION_BITS+4:0]  u,
   input  logic [eis_pkg::TAB_W-1:0]        cdf,
   input  logic [eis_pkg::TAB_W-1:0]        pdf,
   input  eis_pkg::eis_side_type            side,
   input  logic                             hi,
   input  logic                             lo,
   output logic                             rsp_strobe,
   output logic signed [31:0]               rsp_criterion,
   output logic signed [31:0]               rsp_partial_slope,
   output logic                             rsp_sd_zero
);
   import eis_pkg::*;

   localparam int UCW = FRACTION_BITS + 5 + TAB_W + 1;
   localparam int PW  = 34;

   // products against the table words
   logic signed [UCW-1:0] m_ucdf_in, m_ucdf_ff;
   logic signed [63:0]    m_mcdf_in, m_mcdf_ff;
   logic signed [63:0]    m_spdf_in, m_spdf_ff;
   logic [TAB_W-1:0]      m_pdf_ff;
   eis_side_type          m_side_ff;
   logic                  m_hi_ff, m_lo_ff, m_vld_ff;

   assign m_ucdf_in = u * $signed({1'b0, cdf});
   assign m_mcdf_in = $signed(side.ms) * $signed({1'b0, cdf});
   assign m_spdf_in = $signed(side.ss) * $signed({1'b0, pdf});

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= in_vld;
      end
      m_ucdf_ff <= m_ucdf_in;
      m_mcdf_ff <= m_mcdf_in;
      m_spdf_ff <= m_spdf_in;
      m_pdf_ff  <= pdf;
      m_side_ff <= side;
      m_hi_ff   <= hi;
      m_lo_ff   <= lo;
   end

   // u*Phi + phi in Q28, and the saturated slope
   logic signed [PW-1:0]  p_p_in, p_p_ff;
   logic signed [63:0]    p_dsub;
   logic signed [31:0]    p_part_in, p_part_ff;
   eis_side_type          p_side_ff;
   logic                  p_hi_ff, p_lo_ff, p_vld_ff;

   assign p_p_in    = PW'(m_ucdf_ff >>> (FRACTION_BITS + 2)) + PW'(m_pdf_ff >> 2);
   assign p_dsub    = m_mcdf_ff - m_spdf_ff;
   assign p_part_in = sat32(WIDE_W'(p_dsub >>> 30));

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= m_vld_ff;
      end
      p_p_ff    <= p_p_in;
      p_part_ff <= p_part_in;
      p_side_ff <= m_side_ff;
      p_hi_ff   <= m_hi_ff;
      p_lo_ff   <= m_lo_ff;
   end

   // scale by the deviation
   logic signed [WIDE_W-1:0] s_prod_in, s_prod_ff;
   logic signed [31:0]       s_part_ff;
   eis_side_type             s_side_ff;
   logic                     s_hi_ff, s_lo_ff, s_vld_ff;

   assign s_prod_in = $signed({1'b0, p_side_ff.sd}) * p_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else begin
         s_vld_ff <= p_vld_ff;
      end
      s_prod_ff <= s_prod_in;
      s_part_ff <= p_part_ff;
      s_side_ff <= p_side_ff;
      s_hi_ff   <= p_hi_ff;
      s_lo_ff   <= p_lo_ff;
   end

   // final select between table result, zero deviation and the saturated ends
   logic signed [31:0] crit_in, crit_ff;
   logic signed [31:0] part_in, part_ff;
   logic               zero_ff, strobe_ff;

   always_comb begin
      if (s_side_ff.zero || s_lo_ff) begin
         crit_in = '0;
         part_in = '0;
      end else if (s_hi_ff) begin
         crit_in = sat32(-WIDE_W'($signed(s_side_ff.diff)));
         part_in = s_side_ff.ms;
      end else begin
         crit_in = sat32(-(s_prod_ff >>> 28));
         part_in = s_part_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= s_vld_ff;
      end
      crit_ff <= crit_in;
      part_ff <= part_in;
      zero_ff <= s_side_ff.zero;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_criterion     = crit_ff;
   assign rsp_partial_slope = part_ff;
   assign rsp_sd_zero       = zero_ff;

`ifndef SYNTHESIS
   // every result beat comes from an item four stages back
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(in_vld, 4))
      else $error("result beat without an entering item");
   // zero deviation forces both results to zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_sd_zero |-> rsp_criterion == 0 && rsp_partial_slope == 0)
      else $error("zero deviation with non-zero result");
`endif

endmodule

[verif/eis_score_checker.sv]
module eis_score_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic signed [31:0]         req_pred_mean,
   input  logic [30:0]                req_pred_sd,
   input  logic signed [31:0]         req_mean_slope,
   input  logic signed [31:0]         req_sd_slope,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [eis_pkg::CSR_IW-1:0] csr_index,
   input  logic [31:0]                csr_data,
   input  logic                       rsp_strobe,
   input  logic signed [31:0]         rsp_criterion,
   input  logic signed [31:0]         rsp_partial_slope,
   input  logic                       rsp_sd_zero,
   output int                         fail_count,
   output int                         scores_pending
);

   localparam int     ENTRIES   = 1024;
   localparam int     FRAC      = 16;
   localparam longint Q30_ONE   = longint'(1) << 30;
   localparam longint Q30_LN2   = 744261118;
   localparam longint Q30_NORM  = 428361012;
   localparam longint U_LIMIT   = longint'(8) << FRAC;

   typedef struct {
      logic signed [31:0] criterion;
      logic signed [31:0] partial_slope;
      logic               sd_zero;
   } score_type;

   longint density_q30 [ENTRIES];
   longint cumulative_q30 [ENTRIES];
   logic signed [31:0] best_minimum;
   logic [30:0]        margin;
   logic [30:0]        penalty;
   score_type          score_queue [$];

   // exp(-x) in Q30 by range reduction and a Taylor series
   function automatic longint exp_neg(longint unsigned x);
      longint unsigned k;
      longint r, term, sum;
      k = x / Q30_LN2;
      if (k >= 62) begin
         return 0;
      end
      r = longint'(x - k * Q30_LN2);
      term = Q30_ONE;
      sum = Q30_ONE;
      for (int n = 1; n <= 13; n++) begin
         term = term * r / (longint'(n) * Q30_ONE);
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      return sum >>> k;
   endfunction

   // normal density at the half-grid point j
   function automatic longint density_at(longint j);
      longint d;
      longint unsigned sq, x;
      d = j - ENTRIES;
      sq = longint'(d * d);
      x = (sq << 35) / (longint'(ENTRIES) * ENTRIES);
      return (exp_neg(x) * Q30_NORM) >>> 30;
   endfunction

   function automatic logic signed [31:0] clamp_word(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic score_type predict_score(longint mean, longint sd, longint ms, longint ss);
      score_type s;
      longint diff, u, idx, p;
      s.sd_zero = 1'b0;
      if (sd == 0) begin
         s.criterion = 0;
         s.partial_slope = 0;
         s.sd_zero = 1'b1;
         return s;
      end
      diff = longint'(best_minimum) - mean + longint'(margin) + longint'(penalty);
      u = diff * (longint'(1) << FRAC) / sd;
      if (u >= U_LIMIT) begin
         s.criterion = clamp_word(-diff);
         s.partial_slope = clamp_word(ms);
      end else if (u < -U_LIMIT) begin
         s.criterion = 0;
         s.partial_slope = 0;
      end else begin
         idx = ((u + U_LIMIT) * ENTRIES) >>> (FRAC + 4);
         if (idx < 0) idx = 0;
         if (idx > ENTRIES - 1) idx = ENTRIES - 1;
         p = ((u * cumulative_q30[idx]) >>> (FRAC + 2)) + (density_q30[idx] >>> 2);
         s.criterion = clamp_word(-((sd * p) >>> 28));
         s.partial_slope = clamp_word((ms * cumulative_q30[idx]
                                       - ss * density_q30[idx]) >>> 30);
      end
      return s;
   endfunction

   // density and simpson-integrated distribution tables
   initial begin
      longint acc, a, m, b;
      acc = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         a = density_at(2 * i);
         m = density_at(2 * i + 1);
         b = density_at(2 * i + 2);
         density_q30[i] = a;
         cumulative_q30[i] = acc;
         acc = acc + 8 * (a + 4 * m + b) / (3 * longint'(ENTRIES));
         if (acc > Q30_ONE) acc = Q30_ONE;
      end
   end

   assign scores_pending = score_queue.size();

   always @(posedge clock) begin
      score_type want;
      if (reset) begin
         best_minimum <= '0;
         margin <= '0;
         penalty <= '0;
         fail_count <= 0;
      end else begin
         // register write beat
         if (csr_valid && csr_ready) begin
            case (csr_index)
               eis_pkg::CSR_BEST:    best_minimum <= csr_data;
               eis_pkg::CSR_MARGIN:  margin <= csr_data[30:0];
               eis_pkg::CSR_PENALTY: penalty <= csr_data[30:0];
               default: ;
            endcase
         end
         // accepted request beat
         if (start && !busy) begin
            score_queue.push_back(predict_score(req_pred_mean, longint'(req_pred_sd),
                                                req_mean_slope, req_sd_slope));
         end
         // result beat against the oldest expectation
         if (rsp_strobe) begin
            if (score_queue.size() == 0) begin
               $display("%0t: unexpected result beat crit %0d slope %0d", $time,
                        rsp_criterion, rsp_partial_slope);
               fail_count <= fail_count + 1;
            end else begin
               want = score_queue.pop_front();
               if (rsp_criterion !== want.criterion || rsp_partial_slope !== want.partial_slope
                   || rsp_sd_zero !== want.sd_zero) begin
                  $display("%0t: mismatch expected crit %0d slope %0d zero %0b, got %0d %0d %0b",
                           $time, want.criterion, want.partial_slope, want.sd_zero,
                           rsp_criterion, rsp_partial_slope, rsp_sd_zero);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

[verif/testbench.sv]
module testbench;

   localparam int LATENCY = 29;
   localparam int STALL_LIMIT = 3000;
   localparam logic [eis_pkg::CSR_IW-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_pred_mean = '0;
   logic [30:0]        req_pred_sd = '0;
   logic signed [31:0] req_mean_slope = '0;
   logic signed [31:0] req_sd_slope = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [eis_pkg::CSR_IW-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic rsp_strobe;
   logic signed [31:0] rsp_criterion, rsp_partial_slope;
   logic rsp_sd_zero;
   int fail_count, scores_pending;
   int stall_cycles = 0;
   int items_sent = 0;
   int settings_used = 0;
   bit steady_phase = 0;
   longint offset_now = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   expected_improvement_score_top uut (.*);

   eis_score_checker checker_inst (.*);

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (start && !busy || csr_valid && csr_ready || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (steady_phase || r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_score(logic signed [31:0] mean, logic [30:0] sd,
                             logic signed [31:0] ms, logic signed [31:0] ss);
      int gap;
      @(negedge clock);
      start = 1'b1;
      req_pred_mean = mean;
      req_pred_sd = sd;
      req_mean_slope = ms;
      req_sd_slope = ss;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_scores();
      @(negedge clock);
      start = 1'b0;
      while (scores_pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_reg(logic [eis_pkg::CSR_IW-1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_setting(logic [31:0] best, logic [31:0] marg, logic [31:0] pen);
      drain_scores();
      write_reg(eis_pkg::CSR_BEST, best);
      write_reg(eis_pkg::CSR_MARGIN, marg);
      write_reg(eis_pkg::CSR_PENALTY, pen);
      write_reg(CSR_UNUSED, $urandom());
      offset_now = longint'($signed(best)) + longint'(marg[30:0]) + longint'(pen[30:0]);
      settings_used++;
   endtask

   // mostly points whose u lands inside the table, the rest raw noise
   task automatic random_scores(int count);
      logic [30:0] sd;
      longint mean, t;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_score($urandom(), ($urandom_range(0, 15) == 0) ? 31'd0 : 31'($urandom()),
                       $urandom(), $urandom());
         end else begin
            sd = ($urandom_range(0, 4) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 1 << 20));
            t = longint'($urandom_range(0, 4800)) - 2400;
            mean = offset_now - (longint'(sd) * t) / 256;
            if (mean > 64'sd2147483647) mean = 64'sd2147483647;
            if (mean < -64'sd2147483648) mean = -64'sd2147483648;
            send_score(mean[31:0], sd, $urandom(), $urandom());
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero deviation, field extremes, both saturation regions
      send_score(32'sd0, 31'd0, 32'sh7FFFFFFF, 32'sh80000000);
      send_score(32'sd0, 31'd65536, 32'sd65536, 32'sd65536);
      send_score(32'sh7FFFFFFF, 31'd1, 32'sh80000000, 32'sh7FFFFFFF);
      send_score(32'sh80000000, 31'd1, 32'sh7FFFFFFF, 32'sh80000000);
      send_score(32'sh80000000, 31'h7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send_score(32'sh7FFFFFFF, 31'h7FFFFFFF, 32'sh80000000, 32'sh80000000);
      send_score(-32'sd524288, 31'd65536, 32'sd12345, -32'sd999);
      send_score(-32'sd524287, 31'd65536, 32'sd12345, -32'sd999);
      send_score(32'sd524288, 31'd65536, -32'sd7, 32'sd3);
      send_score(32'sd524289, 31'd65536, -32'sd7, 32'sd3);
      send_score(-32'sd32768, 31'd65536, 32'sd65536, -32'sd65536);
      send_score(32'sd32768, 31'd32768, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      apply_setting(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_score(32'sh80000000, 31'd1, 32'sh7FFFFFFF, 32'sd0);
      send_score(32'sh80000000, 31'd0, 32'sd1, 32'sd1);
      send_score(32'sh7FFFFFFF, 31'h7FFFFFFF, 32'sd1, 32'sd1);
      random_scores(60);

      // pause the sender until every result is back
      drain_scores();
      apply_setting(32'h80000000, 32'h00000000, 32'h00000000);
      send_score(32'sh7FFFFFFF, 31'd1, 32'sd5, 32'sd5);
      random_scores(60);
      for (int ph = 0; ph < 5; ph++) begin
         apply_setting($urandom(), ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 1 << 18),
                       ($urandom_range(0, 1) != 0) ? $urandom() : $urandom_range(0, 1 << 16));
         steady_phase = (ph == 2);
         random_scores(65);
      end
      steady_phase = 0;
      drain_scores();

      $display("sent %0d score requests over %0d register settings", items_sent, settings_used + 1);
      $display("covered zero deviation, both table saturation regions and word clamping");
      if (fail_count == 0 && scores_pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
src/eis_pkg.sv
src/eis_div.sv
src/eis_table.sv
src/eis_score.sv
src/expected_improvement_score_top.sv
verif/eis_score_checker.sv
verif/testbench.sv
